FILE: design/oled_text_framebuffer_refresh_top_macros.svh
// Assertion macros shared by the frame store refresh design.
`ifndef OLED_TEXT_FRAMEBUFFER_REFRESH_TOP_MACROS_SVH
`define OLED_TEXT_FRAMEBUFFER_REFRESH_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define OTFR_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define OTFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define OTFR_ASSERT(label, ante, cons)
`define OTFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/otfr_pkg.sv
// Shared types, constants and glyph tables of the frame store refresh design.
`default_nettype none
package otfr_pkg;
	localparam int COLUMNS_DEF = 128;
	localparam int PAGES_DEF = 8;
	localparam int CHUNK_BYTES_DEF = 7;

	localparam int PAGE_MAX_W = 3;
	localparam int COL_MAX_W = 7;
	localparam int GLYPH_W = 6;
	localparam int GLYPH_COLS = 5;
	localparam int CELL_COLS = 6;
	localparam int MAX_CHUNK = 7;
	localparam int DATA_W = 56;
	localparam int COUNT_W = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LO = 8'h00;
	localparam logic [7:0] CMD_COL_HI = 8'h10;

	typedef enum logic [1:0] {
		ACT_DRAW = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_SERVICE = 2'd2,
		ACT_NONE = 2'd3
	} otfr_action_t;

	typedef enum logic [1:0] {
		KIND_DRAW = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_SERVICE = 2'd2
	} otfr_kind_t;

	typedef struct packed {
		otfr_kind_t kind;
		logic [PAGE_MAX_W-1:0] page;
		logic [COL_MAX_W-1:0] column;
		logic [GLYPH_W-1:0] glyph;
		logic accepted;
	} otfr_item_t;

	function automatic logic [GLYPH_W-1:0] glyph_index(input logic [7:0] code);
		logic [GLYPH_W-1:0] idx;
		idx = '0;
		if (code >= "0" && code <= "9") begin
			idx = GLYPH_W'(code - "0" + 8'd1);
		end else begin
			unique case (code)
				":": idx = 6'd11;
				".": idx = 6'd12;
				"A": idx = 6'd13;
				"B": idx = 6'd14;
				"C": idx = 6'd15;
				"D": idx = 6'd16;
				"E": idx = 6'd17;
				"F": idx = 6'd18;
				"H": idx = 6'd19;
				"I": idx = 6'd20;
				"K": idx = 6'd21;
				"L": idx = 6'd22;
				"M": idx = 6'd23;
				"N": idx = 6'd24;
				"O": idx = 6'd25;
				"P": idx = 6'd26;
				"R": idx = 6'd27;
				"S": idx = 6'd28;
				"T": idx = 6'd29;
				"U": idx = 6'd30;
				"V": idx = 6'd31;
				"W": idx = 6'd32;
				"Y": idx = 6'd33;
				default: idx = '0;
			endcase
		end
		return idx;
	endfunction

	// column k of the glyph sits in bits 8k+7..8k
	function automatic logic [8*GLYPH_COLS-1:0] glyph_row(input logic [GLYPH_W-1:0] idx);
		logic [8*GLYPH_COLS-1:0] row;
		unique case (idx)
			6'd1: row = 40'h3E4549513E;
			6'd2: row = 40'h00407F4200;
			6'd3: row = 40'h4649516142;
			6'd4: row = 40'h314B454121;
			6'd5: row = 40'h107F121418;
			6'd6: row = 40'h3945454527;
			6'd7: row = 40'h3049494A3C;
			6'd8: row = 40'h0305097101;
			6'd9: row = 40'h3649494936;
			6'd10: row = 40'h1E29494906;
			6'd11: row = 40'h0000363600;
			6'd12: row = 40'h0000606000;
			6'd13: row = 40'h7E1111117E;
			6'd14: row = 40'h364949497F;
			6'd15: row = 40'h224141413E;
			6'd16: row = 40'h1C2241417F;
			6'd17: row = 40'h414949497F;
			6'd18: row = 40'h010909097F;
			6'd19: row = 40'h7F0808087F;
			6'd20: row = 40'h00417F4100;
			6'd21: row = 40'h412214087F;
			6'd22: row = 40'h404040407F;
			6'd23: row = 40'h7F020C027F;
			6'd24: row = 40'h7F1008047F;
			6'd25: row = 40'h3E4141413E;
			6'd26: row = 40'h060909097F;
			6'd27: row = 40'h462919097F;
			6'd28: row = 40'h3149494946;
			6'd29: row = 40'h01017F0101;
			6'd30: row = 40'h3F4040403F;
			6'd31: row = 40'h1F2040201F;
			6'd32: row = 40'h3F4038403F;
			6'd33: row = 40'h0708700807;
			default: row = '0;
		endcase
		return row;
	endfunction
endpackage
`default_nettype wire

FILE: design/otfr_front.sv
// Input front end: accepts items, drops off-screen draws and unused actions, looks up glyphs.
`default_nettype none
module otfr_front import otfr_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int PAGES = PAGES_DEF
) (
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [1:0] action,
	input  wire logic [7:0] cell_page,
	input  wire logic [7:0] cell_column,
	input  wire logic [7:0] char_code,
	input  wire logic link_accepted,
	input  wire logic busy,
	input  wire logic q_full,
	output logic q_push,
	output otfr_item_t q_item
);
	logic on_screen;
	logic keep;
	logic accept;

	assign on_screen = (cell_page < 8'(PAGES))
		&& (({1'b0, cell_column} + 9'(CELL_COLS)) <= 9'(COLUMNS));
	assign in_stall = busy || q_full;
	assign accept = in_valid && !in_stall;
	assign q_push = accept && keep;

	always_comb begin
		q_item.kind = KIND_SERVICE;
		q_item.page = cell_page[PAGE_MAX_W-1:0];
		q_item.column = cell_column[COL_MAX_W-1:0];
		q_item.glyph = glyph_index(char_code);
		q_item.accepted = link_accepted;
		keep = 1'b0;
		unique case (otfr_action_t'(action))
			ACT_DRAW: begin
				q_item.kind = KIND_DRAW;
				keep = on_screen;
			end
			ACT_CLEAR: begin
				q_item.kind = KIND_CLEAR;
				keep = 1'b1;
			end
			ACT_SERVICE: begin
				q_item.kind = KIND_SERVICE;
				keep = 1'b1;
			end
			ACT_NONE: keep = 1'b0;
			default: keep = 1'b0;
		endcase
	end
endmodule
`default_nettype wire

FILE: design/otfr_fifo.sv
// Short item queue between the front end and the frame store engine.
`default_nettype none
`include "oled_text_framebuffer_refresh_top_macros.svh"
module otfr_fifo import otfr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire otfr_item_t push_item,
	input  wire logic pop,
	output otfr_item_t head_item,
	output logic empty,
	output logic full
);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	otfr_item_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`OTFR_ASSERT(fifo_no_overflow, full, !push)
	`OTFR_ASSERT(fifo_no_underflow, empty, !pop)
	`OTFR_ASSERT_NEXT(fifo_push_lands, push && !pop, !empty)
endmodule
`default_nettype wire

FILE: design/otfr_back.sv
// Frame store engine: store memory, clear sweep, glyph writes and link transfer sequencer.
`default_nettype none
`include "oled_text_framebuffer_refresh_top_macros.svh"
module otfr_back import otfr_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int PAGES = PAGES_DEF,
	parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire otfr_item_t q_item,
	output logic q_pop,
	output logic busy,
	output logic out_valid,
	input  wire logic out_stall,
	output logic is_data,
	output logic [7:0] command_byte,
	output logic [DATA_W-1:0] data_bytes,
	output logic [COUNT_W-1:0] byte_count,
	output logic frame_done
);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int COLW1 = COL_W + 1;
	localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int ADDR_W = PAGE_W + COL_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int CHUNK_EFF = (CHUNK_BYTES < 1) ? 1
		: ((CHUNK_BYTES > MAX_CHUNK) ? MAX_CHUNK : CHUNK_BYTES);
	localparam logic [1:0] PHASE_PAGE = 2'd0;
	localparam logic [1:0] PHASE_LO = 2'd1;
	localparam logic [1:0] PHASE_HI = 2'd2;
	localparam logic [1:0] PHASE_DATA = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRAW,
		ST_READ
	} state_t;

	state_t state_q;
	logic init_done_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [PAGE_W-1:0] page_q;
	logic [1:0] phase_q;
	logic [COL_W-1:0] col_q;
	logic [PAGE_W-1:0] item_page_q;
	logic [COL_W-1:0] item_col_q;
	logic [GLYPH_W-1:0] glyph_q;
	logic acc_q;
	logic [2:0] draw_k_q;
	logic [2:0] rd_k_q;
	logic [COUNT_W-1:0] cnt_q;
	logic rd_v_s1;
	logic [2:0] rd_idx_s1;
	logic [7:0] rdata_s1;
	logic [DATA_W-1:0] chunk_q;

	logic out_valid_q;
	logic is_data_q;
	logic [7:0] command_byte_q;
	logic [DATA_W-1:0] data_bytes_q;
	logic [COUNT_W-1:0] byte_count_q;
	logic frame_done_q;

	logic [7:0] mem [MEM_DEPTH];

	logic out_free;
	logic out_load;
	logic [COLW1-1:0] remaining;
	logic [COUNT_W-1:0] chunk;
	logic [COLW1-1:0] next_col;
	logic last_page;
	logic last_read;
	logic [7:0] cmd_byte;
	logic [8*GLYPH_COLS-1:0] row;
	logic [7:0] draw_byte;
	logic mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0] mem_wdata;
	logic mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [DATA_W-1:0] chunk_next;

	assign busy = !init_done_q;
	assign out_valid = out_valid_q;
	assign is_data = is_data_q;
	assign command_byte = command_byte_q;
	assign data_bytes = data_bytes_q;
	assign byte_count = byte_count_q;
	assign frame_done = frame_done_q;

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_IDLE && q_pop && q_item.kind == KIND_SERVICE
			&& phase_q != PHASE_DATA)
		|| (state_q == ST_READ && last_read);
	assign remaining = COLW1'(COLUMNS) - {1'b0, col_q};
	assign chunk = (remaining > COLW1'(CHUNK_EFF)) ? COUNT_W'(CHUNK_EFF)
		: remaining[COUNT_W-1:0];
	assign next_col = {1'b0, col_q} + COLW1'(cnt_q);
	assign last_page = (page_q == PAGE_W'(PAGES - 1));
	assign last_read = rd_v_s1 && (rd_idx_s1 == cnt_q - 1'b1);

	assign row = glyph_row(glyph_q);
	assign draw_byte = (draw_k_q < 3'(GLYPH_COLS)) ? row[{draw_k_q, 3'b000} +: 8] : 8'h00;

	assign mem_we = (state_q == ST_CLEAR) || (state_q == ST_DRAW);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q
		: {item_page_q, item_col_q + COL_W'(draw_k_q)};
	assign mem_wdata = (state_q == ST_CLEAR) ? 8'h00 : draw_byte;
	assign mem_re = (state_q == ST_READ) && (COUNT_W'(rd_k_q) < cnt_q);
	assign mem_raddr = {page_q, col_q + COL_W'(rd_k_q)};

	always_comb begin
		chunk_next = chunk_q;
		chunk_next[{rd_idx_s1, 3'b000} +: 8] = rdata_s1;
	end

	always_comb begin
		unique case (phase_q)
			PHASE_PAGE: cmd_byte = CMD_PAGE_BASE | 8'(page_q);
			PHASE_LO: cmd_byte = CMD_COL_LO;
			PHASE_HI: cmd_byte = CMD_COL_HI;
			PHASE_DATA: cmd_byte = 8'h00;
			default: cmd_byte = 8'h00;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		if (state_q == ST_IDLE && !q_empty) begin
			q_pop = (q_item.kind == KIND_SERVICE) ? out_free : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			init_done_q <= 1'b0;
			clr_addr_q <= '0;
			page_q <= '0;
			phase_q <= PHASE_PAGE;
			col_q <= '0;
			draw_k_q <= '0;
			rd_k_q <= '0;
			rd_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= mem_re;
			rd_idx_s1 <= rd_k_q;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == {ADDR_W{1'b1}}) begin
						state_q <= ST_IDLE;
						init_done_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_item.kind)
							KIND_DRAW: begin
								item_page_q <= q_item.page[PAGE_W-1:0];
								item_col_q <= q_item.column[COL_W-1:0];
								glyph_q <= q_item.glyph;
								draw_k_q <= '0;
								state_q <= ST_DRAW;
							end
							KIND_CLEAR: begin
								clr_addr_q <= '0;
								state_q <= ST_CLEAR;
							end
							KIND_SERVICE: begin
								acc_q <= q_item.accepted;
								if (phase_q != PHASE_DATA) begin
									is_data_q <= 1'b0;
									command_byte_q <= cmd_byte;
									data_bytes_q <= '0;
									byte_count_q <= COUNT_W'(1);
									frame_done_q <= 1'b0;
									if (q_item.accepted) begin
										phase_q <= phase_q + 1'b1;
									end
								end else begin
									cnt_q <= chunk;
									rd_k_q <= '0;
									chunk_q <= '0;
									state_q <= ST_READ;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DRAW: begin
					draw_k_q <= draw_k_q + 1'b1;
					if (draw_k_q == 3'(CELL_COLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (mem_re) begin
						rd_k_q <= rd_k_q + 1'b1;
					end
					if (rd_v_s1) begin
						chunk_q <= chunk_next;
					end
					if (last_read) begin
						is_data_q <= 1'b1;
						command_byte_q <= 8'h00;
						data_bytes_q <= chunk_next;
						byte_count_q <= cnt_q;
						frame_done_q <= acc_q && (next_col >= COLW1'(COLUMNS)) && last_page;
						if (acc_q) begin
							if (next_col < COLW1'(COLUMNS)) begin
								col_q <= next_col[COL_W-1:0];
							end else begin
								col_q <= '0;
								phase_q <= PHASE_PAGE;
								page_q <= last_page ? '0 : page_q + 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`OTFR_ASSERT(no_read_during_write, mem_we, !mem_re)
	`OTFR_ASSERT(command_has_no_data, out_valid_q && !is_data_q, data_bytes_q == '0 && byte_count_q == COUNT_W'(1) && !frame_done_q)
	`OTFR_ASSERT(chunk_in_range, state_q == ST_READ, cnt_q != '0 && cnt_q <= COUNT_W'(CHUNK_EFF))
endmodule
`default_nettype wire

FILE: design/oled_text_framebuffer_refresh_top.sv
// Command result: registered in the cycle after the service item is popped from the queue head.
// Data chunk result: ST_READ reads the store, one store read per cycle, then registers the chunk.
// Draw writes the CELL_COLS columns of one cell; clear sweeps 2^(page bits + column bits)
// entries, 1024 at defaults, one write per cycle; a 4-entry queue absorbs input.
// Reset clears control state and runs the same clearing sweep; in_stall is high until done.
`default_nettype none
module oled_text_framebuffer_refresh_top import otfr_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int PAGES = PAGES_DEF,
	parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [1:0] action,
	input  wire logic [7:0] cell_page,
	input  wire logic [7:0] cell_column,
	input  wire logic [7:0] char_code,
	input  wire logic link_accepted,
	output logic out_valid,
	input  wire logic out_stall,
	output logic is_data,
	output logic [7:0] command_byte,
	output logic [DATA_W-1:0] data_bytes,
	output logic [COUNT_W-1:0] byte_count,
	output logic frame_done
);
	logic busy;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	otfr_item_t push_item;
	otfr_item_t head_item;

	otfr_front #(
		.COLUMNS(COLUMNS),
		.PAGES(PAGES)
	) u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.cell_page(cell_page),
		.cell_column(cell_column),
		.char_code(char_code),
		.link_accepted(link_accepted),
		.busy(busy),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(push_item)
	);

	otfr_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(push_item),
		.pop(q_pop),
		.head_item(head_item),
		.empty(q_empty),
		.full(q_full)
	);

	otfr_back #(
		.COLUMNS(COLUMNS),
		.PAGES(PAGES),
		.CHUNK_BYTES(CHUNK_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_item(head_item),
		.q_pop(q_pop),
		.busy(busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_data(is_data),
		.command_byte(command_byte),
		.data_bytes(data_bytes),
		.byte_count(byte_count),
		.frame_done(frame_done)
	);
endmodule
`default_nettype wire
